// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication, disabled while in reset
`define AST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== rtl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// types, codes and character helpers shared by the tokenizer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT    = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_BLOCK    = 4'd2,
    KIND_MOVE     = 4'd3,
    KIND_SYSCALL  = 4'd4,
    KIND_OPEN     = 4'd5,
    KIND_CLOSE    = 4'd6,
    KIND_COLON    = 4'd7,
    KIND_PERCENT  = 4'd8,
    KIND_COMMA    = 4'd9,
    KIND_LINE_END = 4'd10,
    KIND_BAD_CHAR = 4'd11,
    KIND_TOO_LONG = 4'd12
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT,
    MODE_ERROR
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WORD,
    ST_PLAIN,
    ST_CHAR,
    ST_LEND
  } ctrl_state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_WORD,
    EMIT_PLAIN,
    EMIT_CHAR,
    EMIT_LEND
  } emit_t;

  typedef enum logic [3:0] {
    CC_LETTER,
    CC_DIGIT,
    CC_UNDER,
    CC_DOT,
    CC_SEMI,
    CC_SPACE,
    CC_SLASH,
    CC_PUNCT,
    CC_OTHER
  } char_class_t;

  localparam int KW_MAX_LEN     = 7;
  localparam int KW_BLOCK_LEN   = 5;
  localparam int KW_MOVE_LEN    = 4;
  localparam int KW_SYSCALL_LEN = 7;

  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_OPEN    = 8'h7B;
  localparam logic [7:0] CH_CLOSE   = 8'h7D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  eval;
    emit_t emit;
    logic  load;
    logic  commit;
  } ast_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_word;
    logic has_plain;
    logic has_char;
    logic has_lend;
    logic word_end;
    logic out_free;
  } ast_status_t;

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t r;
    priority if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) r = CC_LETTER;
    else if (c >= 8'h30 && c <= 8'h39) r = CC_DIGIT;
    else if (c == CH_UNDER) r = CC_UNDER;
    else if (c == CH_DOT) r = CC_DOT;
    else if (c == CH_SEMI) r = CC_SEMI;
    else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) r = CC_SPACE;
    else if (c == CH_SLASH) r = CC_SLASH;
    else if (c == CH_OPEN || c == CH_CLOSE || c == CH_COLON || c == CH_PERCENT ||
             c == CH_COMMA) r = CC_PUNCT;
    else r = CC_OTHER;
    return r;
  endfunction

  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t r;
    priority if (c == CH_OPEN) r = KIND_OPEN;
    else if (c == CH_CLOSE) r = KIND_CLOSE;
    else if (c == CH_COLON) r = KIND_COLON;
    else if (c == CH_PERCENT) r = KIND_PERCENT;
    else r = KIND_COMMA;
    return r;
  endfunction

  // per keyword: does character c sit at position idx of it
  // bit 0 block, bit 1 move, bit 2 syscall
  function automatic logic [2:0] kw_match(input logic [7:0] c, input logic [2:0] idx);
    logic [7:0] cb;
    logic [7:0] cm;
    logic [7:0] cs;
    unique case (idx)
      3'd0: begin cb = "b"; cm = "m"; cs = "s"; end
      3'd1: begin cb = "l"; cm = "o"; cs = "y"; end
      3'd2: begin cb = "o"; cm = "v"; cs = "s"; end
      3'd3: begin cb = "c"; cm = "e"; cs = "c"; end
      3'd4: begin cb = "k"; cm = 8'h00; cs = "a"; end
      3'd5: begin cb = 8'h00; cm = 8'h00; cs = "l"; end
      3'd6: begin cb = 8'h00; cm = 8'h00; cs = "l"; end
      default: begin cb = 8'h00; cm = 8'h00; cs = 8'h00; end
    endcase
    return {(idx < 3'(KW_SYSCALL_LEN)) && (c == cs),
            (idx < 3'(KW_MOVE_LEN)) && (c == cm),
            (idx < 3'(KW_BLOCK_LEN)) && (c == cb)};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ast_in_if.sv =====
// ----------------------------------------------------------------------------
// ast_in_if
// source text channel: one character and its final flag per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/ast_out_if.sv =====
// ----------------------------------------------------------------------------
// ast_out_if
// token channel: one token result per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ast_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_char;
  logic       token_text_last;
  logic       last;

  modport source (output valid, output token_kind, output token_char,
                  output token_text_last, output last, input ready);
  modport sink (input valid, input token_kind, input token_char,
                input token_text_last, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ast_ctrl.sv =====
// ----------------------------------------------------------------------------
// ast_ctrl
// sequencer: takes a character, then walks its result steps in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ast_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ast_pkg::ast_status_t   status,
  output ast_pkg::ast_cmd_t      cmd
);

  ast_pkg::ctrl_state_t state;
  ast_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ast_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = ast_pkg::EMIT_NONE;
    in_ready   = (state == ast_pkg::ST_IDLE);
    unique case (state)
      ast_pkg::ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = ast_pkg::ST_EVAL;
      end
      ast_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (status.has_word) state_next = ast_pkg::ST_WORD;
        else if (status.has_plain) state_next = ast_pkg::ST_PLAIN;
        else if (status.has_char) state_next = ast_pkg::ST_CHAR;
        else if (status.has_lend) state_next = ast_pkg::ST_LEND;
        else begin
          cmd.commit = 1'b1;
          state_next = ast_pkg::ST_IDLE;
        end
      end
      ast_pkg::ST_WORD: begin
        cmd.emit = ast_pkg::EMIT_WORD;
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (status.word_end) begin
            priority if (status.has_plain) state_next = ast_pkg::ST_PLAIN;
            else if (status.has_char) state_next = ast_pkg::ST_CHAR;
            else if (status.has_lend) state_next = ast_pkg::ST_LEND;
            else begin
              cmd.commit = 1'b1;
              state_next = ast_pkg::ST_IDLE;
            end
          end
        end
      end
      ast_pkg::ST_PLAIN: begin
        cmd.emit = ast_pkg::EMIT_PLAIN;
        if (status.out_free) begin
          cmd.load = 1'b1;
          priority if (status.has_char) state_next = ast_pkg::ST_CHAR;
          else if (status.has_lend) state_next = ast_pkg::ST_LEND;
          else begin
            cmd.commit = 1'b1;
            state_next = ast_pkg::ST_IDLE;
          end
        end
      end
      ast_pkg::ST_CHAR: begin
        cmd.emit = ast_pkg::EMIT_CHAR;
        if (status.out_free) begin
          cmd.load = 1'b1;
          if (status.has_lend) begin
            state_next = ast_pkg::ST_LEND;
          end else begin
            cmd.commit = 1'b1;
            state_next = ast_pkg::ST_IDLE;
          end
        end
      end
      ast_pkg::ST_LEND: begin
        cmd.emit = ast_pkg::EMIT_LEND;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.commit = 1'b1;
          state_next = ast_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ast_pkg::ST_IDLE;
      end
    endcase
  end

  `AST_ASSERT_NEXT(a_accept_then_eval, clk, rst, in_valid && in_ready, state == ast_pkg::ST_EVAL)
  `AST_ASSERT_NEXT(a_commit_then_idle, clk, rst, cmd.commit, state == ast_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/ast_dp.sv =====
// ----------------------------------------------------------------------------
// ast_dp
// scanner state, word buffer, result plan and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ast_dp #(
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  input  ast_pkg::ast_cmd_t    cmd,
  output ast_pkg::ast_status_t status,
  ast_out_if.source            tok
);

  localparam int AW  = $clog2(MAX_WORD_LEN);
  localparam int WLW = $clog2(MAX_WORD_LEN + 1);

  // held character
  logic [7:0] byte_h;
  logic       fin_h;

  // scanner state
  ast_pkg::scan_mode_t mode;
  logic [WLW-1:0]      wl;
  logic                lht;
  logic [2:0]          kw;

  // word buffer
  logic [7:0]    mem [MAX_WORD_LEN];
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_idx_next;
  logic [7:0]    rd_data;

  // registered plan for the held character
  logic                has_word;
  logic                has_plain;
  logic                has_char;
  logic                has_lend;
  logic                word_kw;
  logic                word_open;
  ast_pkg::tok_kind_t  word_kind;
  ast_pkg::tok_kind_t  plain_kind;
  logic [7:0]          plain_char;
  ast_pkg::tok_kind_t  char_kind;

  // plan and pending state, worked out from the held character
  logic                n_word;
  logic                n_plain;
  logic                n_char;
  logic                n_lend;
  logic                n_word_kw;
  logic                n_word_open;
  ast_pkg::tok_kind_t  n_word_kind;
  ast_pkg::tok_kind_t  n_plain_kind;
  logic [7:0]          n_plain_char;
  ast_pkg::tok_kind_t  n_char_kind;
  ast_pkg::scan_mode_t p_mode;
  logic [WLW-1:0]      p_wl;
  logic                p_lht;
  logic [2:0]          p_kw;
  logic                p_we;
  logic [AW-1:0]       p_waddr;

  ast_pkg::char_class_t cls;
  logic                 cont;
  logic                 in_word;
  logic                 do_plain;
  logic                 lht_in;
  logic                 start;
  logic [2:0]           hit;
  logic [2:0]           ext_kw;
  logic [2:0]           cur_found;
  logic [2:0]           ext_found;
  logic [WLW-1:0]       wl_inc;
  ast_pkg::tok_kind_t   cur_word_kind;

  // output register
  logic               out_valid;
  ast_pkg::tok_kind_t o_kind;
  logic [7:0]         o_char;
  logic               o_tl;
  logic               o_last;
  logic               last_idx;

  function automatic logic [2:0] kw_found(input logic [WLW-1:0] len, input logic [2:0] f);
    return {f[2] && (len == WLW'(ast_pkg::KW_SYSCALL_LEN)),
            f[1] && (len == WLW'(ast_pkg::KW_MOVE_LEN)),
            f[0] && (len == WLW'(ast_pkg::KW_BLOCK_LEN))};
  endfunction

  function automatic ast_pkg::tok_kind_t kw_kind(input logic [2:0] fnd);
    ast_pkg::tok_kind_t r;
    priority if (fnd[0]) r = ast_pkg::KIND_BLOCK;
    else if (fnd[1]) r = ast_pkg::KIND_MOVE;
    else r = ast_pkg::KIND_SYSCALL;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_h <= text_byte;
      fin_h  <= end_of_text;
    end
  end

  // ---------------------------------------------------------------------------
  // result plan and pending state
  // ---------------------------------------------------------------------------
  always_comb begin
    cls           = ast_pkg::char_class(byte_h);
    in_word       = (mode == ast_pkg::MODE_IDENT) || (mode == ast_pkg::MODE_NUMBER);
    cont          = (mode == ast_pkg::MODE_IDENT)
                    ? (cls == ast_pkg::CC_LETTER || cls == ast_pkg::CC_DIGIT ||
                       cls == ast_pkg::CC_UNDER)
                    : (cls == ast_pkg::CC_DIGIT || cls == ast_pkg::CC_DOT);
    hit           = (wl < WLW'(ast_pkg::KW_MAX_LEN)) ? ast_pkg::kw_match(byte_h, wl[2:0]) : 3'b000;
    ext_kw        = kw & hit;
    wl_inc        = wl + WLW'(1);
    cur_found     = (mode == ast_pkg::MODE_IDENT) ? kw_found(wl, kw) : 3'b000;
    ext_found     = (mode == ast_pkg::MODE_IDENT) ? kw_found(wl_inc, ext_kw) : 3'b000;
    cur_word_kind = (mode == ast_pkg::MODE_IDENT) ? ast_pkg::KIND_IDENT : ast_pkg::KIND_NUMBER;

    p_mode        = mode;
    p_wl          = wl;
    p_lht         = lht;
    p_kw          = kw;
    p_we          = 1'b0;
    p_waddr       = '0;
    n_word        = 1'b0;
    n_plain       = 1'b0;
    n_char        = 1'b0;
    n_lend        = 1'b0;
    n_word_kw     = 1'b0;
    n_word_open   = 1'b0;
    n_word_kind   = cur_word_kind;
    n_plain_kind  = ast_pkg::KIND_LINE_END;
    n_plain_char  = 8'h00;
    n_char_kind   = cur_word_kind;
    do_plain      = 1'b0;
    lht_in        = lht;
    start         = 1'b0;

    unique case (mode)
      ast_pkg::MODE_IDENT, ast_pkg::MODE_NUMBER: begin
        if (cont) begin
          if (wl == WLW'(MAX_WORD_LEN)) begin
            p_mode       = ast_pkg::MODE_ERROR;
            p_wl         = '0;
            n_plain      = 1'b1;
            n_plain_kind = ast_pkg::KIND_TOO_LONG;
            n_plain_char = byte_h;
          end else begin
            p_wl    = wl_inc;
            p_we    = 1'b1;
            p_waddr = wl[AW-1:0];
            p_kw    = ext_kw;
            // final character closes the word with itself as the tail
            if (fin_h) begin
              n_word = 1'b1;
              if (ext_found != 3'b000) begin
                n_word_kw   = 1'b1;
                n_word_kind = kw_kind(ext_found);
              end else begin
                n_word_open = 1'b1;
                n_char      = 1'b1;
              end
            end
          end
        end else begin
          n_word   = 1'b1;
          do_plain = 1'b1;
          lht_in   = 1'b1;
          if (cur_found != 3'b000) begin
            n_word_kw   = 1'b1;
            n_word_kind = kw_kind(cur_found);
          end
        end
      end
      ast_pkg::MODE_COMMENT: begin
        if (cls == ast_pkg::CC_SEMI) begin
          p_mode  = ast_pkg::MODE_NORMAL;
          p_lht   = 1'b0;
          n_plain = lht;
        end
      end
      ast_pkg::MODE_ERROR: begin
        p_mode = ast_pkg::MODE_ERROR;
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      p_mode = ast_pkg::MODE_NORMAL;
      p_lht  = lht_in;
      p_wl   = '0;
      unique case (cls)
        ast_pkg::CC_SEMI: begin
          p_lht   = 1'b0;
          n_plain = lht_in;
        end
        ast_pkg::CC_LETTER, ast_pkg::CC_DIGIT: begin
          p_mode  = (cls == ast_pkg::CC_LETTER) ? ast_pkg::MODE_IDENT : ast_pkg::MODE_NUMBER;
          p_wl    = WLW'(1);
          p_we    = 1'b1;
          p_waddr = '0;
          p_kw    = ast_pkg::kw_match(byte_h, 3'd0);
          start   = 1'b1;
        end
        ast_pkg::CC_SPACE: begin
        end
        ast_pkg::CC_SLASH: begin
          p_mode = ast_pkg::MODE_COMMENT;
        end
        ast_pkg::CC_PUNCT: begin
          n_plain      = 1'b1;
          n_plain_kind = ast_pkg::punct_kind(byte_h);
          p_lht        = 1'b1;
        end
        default: begin
          p_mode       = ast_pkg::MODE_ERROR;
          n_plain      = 1'b1;
          n_plain_kind = ast_pkg::KIND_BAD_CHAR;
          n_plain_char = byte_h;
        end
      endcase
    end

    if (fin_h && start) begin
      n_char      = 1'b1;
      n_char_kind = (cls == ast_pkg::CC_LETTER) ? ast_pkg::KIND_IDENT : ast_pkg::KIND_NUMBER;
    end
    // a pending word is flushed at the end, which marks the line as used
    n_lend = fin_h && (p_mode != ast_pkg::MODE_ERROR) &&
             (p_lht || p_mode == ast_pkg::MODE_IDENT || p_mode == ast_pkg::MODE_NUMBER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_word  <= 1'b0;
      has_plain <= 1'b0;
      has_char  <= 1'b0;
      has_lend  <= 1'b0;
    end else if (cmd.eval) begin
      has_word  <= n_word;
      has_plain <= n_plain;
      has_char  <= n_char;
      has_lend  <= n_lend;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      word_kw    <= n_word_kw;
      word_open  <= n_word_open;
      word_kind  <= n_word_kind;
      plain_kind <= n_plain_kind;
      plain_char <= n_plain_char;
      char_kind  <= n_char_kind;
    end
  end

  // ---------------------------------------------------------------------------
  // scanner state, updated once per character
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ast_pkg::MODE_NORMAL;
      wl   <= '0;
      lht  <= 1'b0;
    end else if (cmd.commit) begin
      if (fin_h) begin
        mode <= ast_pkg::MODE_NORMAL;
        wl   <= '0;
        lht  <= 1'b0;
      end else begin
        mode <= p_mode;
        wl   <= p_wl;
        lht  <= p_lht;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) kw <= p_kw;
  end

  // ---------------------------------------------------------------------------
  // word buffer, read one character ahead of the output
  // ---------------------------------------------------------------------------
  assign last_idx = ((WLW'(rd_idx) + WLW'(1)) == wl);

  always_comb begin
    if (cmd.eval) begin
      rd_idx_next = '0;
    end else if (cmd.load && cmd.emit == ast_pkg::EMIT_WORD) begin
      rd_idx_next = last_idx ? '0 : rd_idx + AW'(1);
    end else begin
      rd_idx_next = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else begin
      rd_idx <= rd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !fin_h && p_we) mem[p_waddr] <= byte_h;
    rd_data <= mem[rd_idx_next];
  end

  // ---------------------------------------------------------------------------
  // status and output item
  // ---------------------------------------------------------------------------
  always_comb begin
    status.has_word  = cmd.eval ? n_word  : has_word;
    status.has_plain = cmd.eval ? n_plain : has_plain;
    status.has_char  = cmd.eval ? n_char  : has_char;
    status.has_lend  = cmd.eval ? n_lend  : has_lend;
    status.word_end  = word_kw || last_idx;
    status.out_free  = !out_valid || tok.ready;
  end

  always_comb begin
    unique case (cmd.emit)
      ast_pkg::EMIT_WORD: begin
        o_kind = word_kind;
        o_char = word_kw ? 8'h00 : rd_data;
        o_tl   = word_kw || (last_idx && !word_open);
        o_last = (word_kw || last_idx) && !has_plain && !has_char && !has_lend;
      end
      ast_pkg::EMIT_PLAIN: begin
        o_kind = plain_kind;
        o_char = plain_char;
        o_tl   = 1'b1;
        o_last = !has_char && !has_lend;
      end
      ast_pkg::EMIT_CHAR: begin
        o_kind = char_kind;
        o_char = byte_h;
        o_tl   = 1'b1;
        o_last = !has_lend;
      end
      ast_pkg::EMIT_LEND: begin
        o_kind = ast_pkg::KIND_LINE_END;
        o_char = 8'h00;
        o_tl   = 1'b1;
        o_last = 1'b1;
      end
      default: begin
        o_kind = ast_pkg::KIND_LINE_END;
        o_char = 8'h00;
        o_tl   = 1'b0;
        o_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (tok.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok.token_kind      <= o_kind;
      tok.token_char      <= o_char;
      tok.token_text_last <= o_tl;
      tok.last            <= o_last;
    end
  end

  assign tok.valid = out_valid;

  `AST_ASSERT_IMPLY(a_load_into_free_slot, clk, rst, cmd.load, !out_valid || tok.ready)
  `AST_ASSERT_IMPLY(a_word_mode_has_chars, clk, rst, (mode == ast_pkg::MODE_IDENT) || (mode == ast_pkg::MODE_NUMBER), wl != '0)
  `AST_ASSERT_IMPLY(a_other_mode_no_chars, clk, rst, (mode == ast_pkg::MODE_NORMAL) || (mode == ast_pkg::MODE_COMMENT) || (mode == ast_pkg::MODE_ERROR), wl == '0)
  `AST_ASSERT_IMPLY(a_flush_index_in_word, clk, rst, (cmd.emit == ast_pkg::EMIT_WORD) && !word_kw, WLW'(rd_idx) < wl)

endmodule

`default_nettype wire

// ===== rtl/assembly_source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// streaming lexer for a small assembly language, one character per item in
// ----------------------------------------------------------------------------
// text_in takes one character per item with end_of_text on the final one.
// token_out gives one token result per item: kind, character, a flag on the
// last character of a token and a flag on the last result of a character.
// Words are held in a buffer of MAX_WORD_LEN characters and sent one
// character per item when the word closes; keywords come out as one item.
// A character is taken into a holding register and decoded in the cycle
// after; its results are then loaded into the output register in order
// while token_out is ready, and one that gives no result goes back to
// idle once decoded. A word is flushed from the buffer one character per
// cycle while token_out is ready.
// A stall on token_out holds the sequencer; the output register keeps its
// item until taken, and text_in is not ready until all results of the
// current character have been loaded.
// Reset (synchronous, active high) returns to line start with no token and
// an empty word; the buffer contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module assembly_source_tokenizer #(
  parameter int MAX_WORD_LEN = 32
) (
  input  logic      clk,
  input  logic      rst,
  ast_in_if.sink    text_in,
  ast_out_if.source token_out
);

  ast_pkg::ast_cmd_t    cmd;
  ast_pkg::ast_status_t status;

  ast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_ready (text_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ast_dp #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (text_in.text_byte),
    .end_of_text (text_in.end_of_text),
    .cmd         (cmd),
    .status      (status),
    .tok         (token_out)
  );

endmodule

`default_nettype wire
